/* rtl/sarsi_pkg.sv */
// package: types and constants shared by the simple-average rsi block
package sarsi_pkg;

    localparam int PRICE_IN_W = 32;
    localparam int TS_W       = 64;
    localparam int RSI_W      = 23;
    localparam int THR_W      = 23;
    localparam int CFG_DATA_W = 23;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_PERIOD_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_LEN      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_LEVEL = 1'b1;

    localparam int PERIOD_RESET = 14;
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 23'd4587520;

    localparam logic [RSI_W-1:0] RSI_SCALE = 23'd6553600;
    localparam logic [RSI_W-1:0] RSI_HALF  = 23'd3276800;
    localparam logic [RSI_W-1:0] RSI_ZERO  = 23'd0;

    // 6553600 = 25 << 18
    localparam int RSI_SCALE_MUL   = 25;
    localparam int RSI_MUL_W       = 5;
    localparam int RSI_SCALE_SHIFT = 18;

    localparam int Q_BITS    = 24;
    localparam int DIV_STEPS = Q_BITS / 2;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        JOB_DIVIDE,
        JOB_HALF,
        JOB_FULL,
        JOB_ZERO
    } job_kind_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_RD_OLD,
        F_RD_SEC,
        F_ADD,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_WRITE
    } back_state_t;

    typedef struct packed {
        logic [PRICE_IN_W-1:0] price;
        logic [TS_W-1:0]       time_stamp;
    } in_item_t;

    typedef struct packed {
        logic [RSI_W-1:0] rsi_value;
        logic [THR_W-1:0] threshold_out;
        logic [TS_W-1:0]  time_stamp_out;
    } out_item_t;

    typedef struct packed {
        job_kind_t        kind;
        logic [THR_W-1:0] threshold;
        logic [TS_W-1:0]  time_stamp;
    } job_info_t;

endpackage

/* rtl/sarsi_ram.sv */
// generic single-port-write ram with registered read
module sarsi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/sarsi_fifo.sv */
// small job queue between the window front end and the divider back end
module sarsi_fifo #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == COUNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(DEPTH))
        else $error("job queue count beyond depth");
`endif

endmodule

/* rtl/sarsi_front.sv */
// front end: config registers, price window, running rise and fall sums, job classification
module sarsi_front
    import sarsi_pkg::*;
#(
    parameter int MAX_PERIOD  = 64,
    parameter int PRICE_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    output logic                  full,
    input  in_item_t              in_item,
    output logic                  ram_we,
    output logic [$clog2(MAX_PERIOD+1)-1:0] ram_waddr,
    output logic [((PRICE_WIDTH < PRICE_IN_W) ? PRICE_WIDTH : PRICE_IN_W)-1:0] ram_wdata,
    output logic [$clog2(MAX_PERIOD+1)-1:0] ram_raddr,
    input  logic [((PRICE_WIDTH < PRICE_IN_W) ? PRICE_WIDTH : PRICE_IN_W)-1:0] ram_rdata,
    output logic                  job_push,
    input  logic                  job_full,
    output job_info_t             job_info,
    output logic [((PRICE_WIDTH < PRICE_IN_W) ? PRICE_WIDTH : PRICE_IN_W)
                  + $clog2(MAX_PERIOD)-1:0] job_rise,
    output logic [((PRICE_WIDTH < PRICE_IN_W) ? PRICE_WIDTH : PRICE_IN_W)
                  + $clog2(MAX_PERIOD)-1:0] job_total
);

    localparam int PW     = (PRICE_WIDTH < PRICE_IN_W) ? PRICE_WIDTH : PRICE_IN_W;
    localparam int SUM_W  = PW + $clog2(MAX_PERIOD);
    localparam int PER_W  = $clog2(MAX_PERIOD + 1);
    localparam int LEN_W  = $clog2(MAX_PERIOD + 2);
    localparam int ADDR_W = $clog2(MAX_PERIOD + 1);
    localparam int PERIOD_INIT = (PERIOD_RESET < MAX_PERIOD) ? PERIOD_RESET : MAX_PERIOD;

    front_state_t      state_reg, state_next;
    logic [PER_W-1:0]  period_reg, period_next;
    logic [THR_W-1:0]  threshold_reg, threshold_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [ADDR_W-1:0] slot_reg, slot_next;
    logic [SUM_W-1:0]  rise_reg, rise_next;
    logic [SUM_W-1:0]  fall_reg, fall_next;
    logic [PW-1:0]     price_reg, price_next;
    logic [TS_W-1:0]   ts_reg, ts_next;
    logic [PW-1:0]     newest_reg, newest_next;
    logic [PW-1:0]     oldest_reg, oldest_next;

    logic [LEN_W-1:0]        len;
    logic [LEN_W-1:0]        slot_p1;
    logic                    slot_wrap;
    logic [ADDR_W-1:0]       slot_adv;
    logic                    win_full;
    logic [LEN_W-1:0]        fill_inc;
    logic [CFG_PERIOD_W-1:0] period_wr;
    logic [PER_W-1:0]        period_clamp;

    assign len       = LEN_W'(period_reg) + 1'b1;
    assign slot_p1   = LEN_W'(slot_reg) + 1'b1;
    assign slot_wrap = (slot_p1 == len);
    assign slot_adv  = slot_wrap ? '0 : ADDR_W'(slot_p1);
    assign win_full  = (fill_reg == len);
    assign fill_inc  = (fill_reg < len) ? fill_reg + 1'b1 : fill_reg;

    assign period_wr    = cfg_data[CFG_PERIOD_W-1:0];
    assign period_clamp = (period_wr == '0) ? PER_W'(1) :
                          (int'(period_wr) > MAX_PERIOD) ? PER_W'(MAX_PERIOD) :
                          PER_W'(period_wr);

    assign full      = (state_reg != F_IDLE);
    assign ram_waddr = slot_reg;
    assign ram_wdata = price_reg;

    assign job_rise  = rise_reg;
    assign job_total = rise_reg + fall_reg;

    always_comb
    begin
        job_info.threshold  = threshold_reg;
        job_info.time_stamp = ts_reg;
        if (rise_reg == '0 && fall_reg == '0)
        begin
            job_info.kind = JOB_HALF;
        end
        else if (fall_reg == '0)
        begin
            job_info.kind = JOB_FULL;
        end
        else if (rise_reg == '0)
        begin
            job_info.kind = JOB_ZERO;
        end
        else
        begin
            job_info.kind = JOB_DIVIDE;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        period_next    = period_reg;
        threshold_next = threshold_reg;
        fill_next      = fill_reg;
        slot_next      = slot_reg;
        rise_next      = rise_reg;
        fall_next      = fall_reg;
        price_next     = price_reg;
        ts_next        = ts_reg;
        newest_next    = newest_reg;
        oldest_next    = oldest_reg;
        ram_we         = 1'b0;
        ram_raddr      = slot_reg;
        job_push       = 1'b0;

        unique case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    price_next = in_item.price[PW-1:0];
                    ts_next    = in_item.time_stamp;
                    state_next = win_full ? F_RD_OLD : F_ADD;
                end
            end
            F_RD_OLD:
            begin
                oldest_next = ram_rdata;
                ram_raddr   = slot_adv;
                state_next  = F_RD_SEC;
            end
            F_RD_SEC:
            begin
                // drop the change between the oldest two prices
                if (ram_rdata > oldest_reg)
                begin
                    rise_next = rise_reg - (SUM_W'(ram_rdata) - SUM_W'(oldest_reg));
                end
                else
                begin
                    fall_next = fall_reg - (SUM_W'(oldest_reg) - SUM_W'(ram_rdata));
                end
                state_next = F_ADD;
            end
            F_ADD:
            begin
                if (fill_reg != '0)
                begin
                    if (price_reg > newest_reg)
                    begin
                        rise_next = rise_reg + (SUM_W'(price_reg) - SUM_W'(newest_reg));
                    end
                    else
                    begin
                        fall_next = fall_reg + (SUM_W'(newest_reg) - SUM_W'(price_reg));
                    end
                end
                ram_we      = 1'b1;
                newest_next = price_reg;
                slot_next   = slot_adv;
                fill_next   = fill_inc;
                state_next  = (fill_inc == len) ? F_PUSH : F_IDLE;
            end
            F_PUSH:
            begin
                if (!job_full)
                begin
                    job_push   = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PERIOD_LEN:
                begin
                    period_next = period_clamp;
                    fill_next   = '0;
                    slot_next   = '0;
                    rise_next   = '0;
                    fall_next   = '0;
                end
                CFG_THRESHOLD_LEVEL:
                begin
                    threshold_next = cfg_data[THR_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            period_reg    <= PER_W'(PERIOD_INIT);
            threshold_reg <= THRESHOLD_RESET;
            fill_reg      <= '0;
            slot_reg      <= '0;
            rise_reg      <= '0;
            fall_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            period_reg    <= period_next;
            threshold_reg <= threshold_next;
            fill_reg      <= fill_next;
            slot_reg      <= slot_next;
            rise_reg      <= rise_next;
            fall_reg      <= fall_next;
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg  <= price_next;
        ts_reg     <= ts_next;
        newest_reg <= newest_next;
        oldest_reg <= oldest_next;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= len)
        else $error("fill count beyond window length");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        LEN_W'(slot_reg) < len)
        else $error("write slot outside window");

    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_PUSH) |-> win_full)
        else $error("job issued before window is full");
`endif

endmodule

/* rtl/sarsi_back.sv */
// back end: special-case results and radix-4 restoring divider, output register
module sarsi_back
    import sarsi_pkg::*;
#(
    parameter int SUM_W = 38
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_empty,
    output logic             job_pop,
    input  job_info_t        job_info,
    input  logic [SUM_W-1:0] job_rise,
    input  logic [SUM_W-1:0] job_total,
    output logic             empty,
    input  logic             pop,
    output out_item_t        out_item
);

    localparam int REM_W = SUM_W + 1;
    localparam int UP_W  = SUM_W + RSI_MUL_W;
    localparam int NUM_W = UP_W + RSI_SCALE_SHIFT;

    back_state_t       state_reg, state_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [Q_BITS-1:0] dvd_reg, dvd_next;
    logic [Q_BITS-1:0] quo_reg, quo_next;
    logic [SUM_W-1:0]  total_reg, total_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [RSI_W-1:0]  res_reg, res_next;
    job_info_t         info_reg, info_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;

    logic [UP_W-1:0]   up_scaled;
    logic [NUM_W-1:0]  num;
    logic [REM_W-1:0]  divisor;
    logic [REM_W-1:0]  r1_shift, r1, r2_shift, r2;
    logic              q1, q2;
    logic [Q_BITS-1:0] quo_step;

    assign up_scaled = UP_W'(job_rise) * UP_W'(RSI_SCALE_MUL);
    assign num       = {up_scaled, {RSI_SCALE_SHIFT{1'b0}}};

    // two quotient bits per cycle
    assign divisor  = REM_W'(total_reg);
    assign r1_shift = {rem_reg[REM_W-2:0], dvd_reg[Q_BITS-1]};
    assign q1       = (r1_shift >= divisor);
    assign r1       = q1 ? r1_shift - divisor : r1_shift;
    assign r2_shift = {r1[REM_W-2:0], dvd_reg[Q_BITS-2]};
    assign q2       = (r2_shift >= divisor);
    assign r2       = q2 ? r2_shift - divisor : r2_shift;
    assign quo_step = {quo_reg[Q_BITS-3:0], q1, q2};

    assign empty    = !out_valid_reg;
    assign out_item = out_item_reg;

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        quo_next       = quo_reg;
        total_next     = total_reg;
        step_next      = step_reg;
        res_next       = res_reg;
        info_next      = info_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        job_pop        = 1'b0;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            B_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop    = 1'b1;
                    info_next  = job_info;
                    total_next = job_total;
                    rem_next   = REM_W'(num[NUM_W-1:Q_BITS]);
                    dvd_next   = num[Q_BITS-1:0];
                    quo_next   = '0;
                    step_next  = STEP_W'(DIV_STEPS - 1);
                    unique case (job_info.kind)
                        JOB_DIVIDE:
                        begin
                            state_next = B_DIV;
                        end
                        JOB_HALF:
                        begin
                            res_next   = RSI_HALF;
                            state_next = B_WRITE;
                        end
                        JOB_FULL:
                        begin
                            res_next   = RSI_SCALE;
                            state_next = B_WRITE;
                        end
                        JOB_ZERO:
                        begin
                            res_next   = RSI_ZERO;
                            state_next = B_WRITE;
                        end
                        default:
                        begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end
            B_DIV:
            begin
                rem_next  = r2;
                dvd_next  = dvd_reg << 2;
                quo_next  = quo_step;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    res_next   = quo_step[RSI_W-1:0];
                    state_next = B_WRITE;
                end
            end
            B_WRITE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_item_next.rsi_value      = res_reg;
                    out_item_next.threshold_out  = info_reg.threshold;
                    out_item_next.time_stamp_out = info_reg.time_stamp;
                    out_valid_next               = 1'b1;
                    state_next                   = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        dvd_reg      <= dvd_next;
        quo_reg      <= quo_next;
        total_reg    <= total_next;
        step_reg     <= step_next;
        res_reg      <= res_next;
        info_reg     <= info_next;
        out_item_reg <= out_item_next;
    end

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIV) |-> (rem_reg < divisor))
        else $error("partial remainder not below divisor");

    a_write_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_WRITE && out_valid_reg && !pop) |=> (state_reg == B_WRITE))
        else $error("result left write state while output slot busy");
`endif

endmodule

/* rtl/simple_average_rsi_core.sv */
// top level: simple moving average rsi with queue-style input and result channels
//
// input channel: an item (price, time stamp) transfers on a clock edge with push high and
// full low. config port: cfg_we writes cfg_data into register cfg_index (0 period_len,
// 1 threshold_level) in the same cycle; write only while no item is in flight. writing
// period_len empties the price window.
// result channel: while empty is low the oldest result is on out_item; it transfers on a
// clock edge with pop high. no result comes until the window holds period_len+1 prices,
// after that each item gives one result.
// datapath order from input transfer to result on the ports: window update, queue hop,
// divider, output register. the front end takes a new item only once it is through with the
// last one (full stays high meanwhile), and the divider works on one result at a time;
// results that need no division (flat, no falls, no rises) skip the divider in the back end.
// a stalled receiver holds the finished result in the output register; the back end
// finishes the next result and the two-entry job queue fills, then full stays high.
// reset clears the window, sums and queues and loads period 14 and threshold 4587520.
module simple_average_rsi_core
    import sarsi_pkg::*;
#(
    parameter int MAX_PERIOD  = 64,
    parameter int PRICE_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    output logic                  full,
    input  in_item_t              in_item,
    output logic                  empty,
    input  logic                  pop,
    output out_item_t             out_item
);

    localparam int PW     = (PRICE_WIDTH < PRICE_IN_W) ? PRICE_WIDTH : PRICE_IN_W;
    localparam int SUM_W  = PW + $clog2(MAX_PERIOD);
    localparam int ADDR_W = $clog2(MAX_PERIOD + 1);
    localparam int DEPTH  = MAX_PERIOD + 1;
    localparam int JOB_W  = $bits(job_info_t) + 2 * SUM_W;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [PW-1:0]     ram_wdata, ram_rdata;

    logic              job_push, job_full, job_pop, job_empty;
    job_info_t         f_info, b_info;
    logic [SUM_W-1:0]  f_rise, f_total, b_rise, b_total;
    logic [JOB_W-1:0]  q_wdata, q_rdata;

    sarsi_front #(
        .MAX_PERIOD  (MAX_PERIOD),
        .PRICE_WIDTH (PRICE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .job_push  (job_push),
        .job_full  (job_full),
        .job_info  (f_info),
        .job_rise  (f_rise),
        .job_total (f_total)
    );

    sarsi_ram #(
        .WIDTH (PW),
        .DEPTH (DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign q_wdata = {f_info, f_rise, f_total};
    assign {b_info, b_rise, b_total} = q_rdata;

    sarsi_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (2)
    ) u_jobs (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .full  (job_full),
        .wdata (q_wdata),
        .pop   (job_pop),
        .empty (job_empty),
        .rdata (q_rdata)
    );

    sarsi_back #(
        .SUM_W (SUM_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .job_info  (b_info),
        .job_rise  (b_rise),
        .job_total (b_total),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item)
    );

endmodule

/* bench/sarsi_result_check.sv */
// result checker for the simple-average rsi block: tracks the window, predicts and compares
module sarsi_result_check
    import sarsi_pkg::*;
#(
    parameter int MAX_PERIOD  = 64,
    parameter int PRICE_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    input  logic                  full,
    input  in_item_t              in_item,
    input  logic                  empty,
    input  logic                  pop,
    input  out_item_t             out_item,
    output int                    mismatch_count,
    output int                    rsi_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [PRICE_WIDTH-1:0] price_ring [0:MAX_PERIOD];
    int                     fill;
    int                     slot;
    int                     span;
    logic [63:0]            rises;
    logic [63:0]            falls;
    logic [THR_W-1:0]       thr;
    out_item_t              expected_rsi [$];

    function automatic void clear_window();
        fill  = 0;
        slot  = 0;
        rises = '0;
        falls = '0;
    endfunction

    function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        int req;
        req = int'(data[CFG_PERIOD_W-1:0]);
        if (idx == CFG_PERIOD_LEN)
        begin
            if (req < 1)
                req = 1;
            if (req > MAX_PERIOD)
                req = MAX_PERIOD;
            span = req;
            clear_window();
        end
        else if (idx == CFG_THRESHOLD_LEVEL)
        begin
            thr = data[THR_W-1:0];
        end
    endfunction

    function automatic void move_sums(logic [63:0] from, logic [63:0] to, bit add);
        if (to > from)
        begin
            if (add)
                rises += to - from;
            else
                rises -= to - from;
        end
        else
        begin
            if (add)
                falls += from - to;
            else
                falls -= from - to;
        end
    endfunction

    function automatic void predict_rsi(in_item_t item);
        int          len;
        logic [63:0] p;
        logic [63:0] total;
        logic [63:0] scaled;
        out_item_t   res;
        len = span + 1;
        p   = 64'(item.price[PRICE_WIDTH-1:0]);
        if (fill == len)
            move_sums(64'(price_ring[slot]), 64'(price_ring[(slot + 1) % len]), 1'b0);
        if (fill > 0)
            move_sums(64'(price_ring[(slot + len - 1) % len]), p, 1'b1);
        price_ring[slot] = p[PRICE_WIDTH-1:0];
        slot = (slot + 1) % len;
        if (fill < len)
            fill++;
        if (fill < len)
            return;
        res.threshold_out  = thr;
        res.time_stamp_out = item.time_stamp;
        if (rises == 0 && falls == 0)
            res.rsi_value = RSI_HALF;
        else if (falls == 0)
            res.rsi_value = RSI_SCALE;
        else if (rises == 0)
            res.rsi_value = RSI_ZERO;
        else
        begin
            total         = rises + falls;
            scaled        = rises * 64'(RSI_SCALE);
            res.rsi_value = RSI_W'(scaled / total);
        end
        expected_rsi.insert(expected_rsi.size(), res);
    endfunction

    function automatic void check_rsi(out_item_t got);
        out_item_t want;
        if (expected_rsi.size() == 0)
        begin
            $error("result transfer with none pending: rsi %0d, time stamp %h",
                   got.rsi_value, got.time_stamp_out);
            mismatch_count++;
            return;
        end
        want = expected_rsi.pop_front();
        if (got.rsi_value !== want.rsi_value)
        begin
            $error("rsi_value mismatch: expected %0d, actual %0d", want.rsi_value, got.rsi_value);
            mismatch_count++;
        end
        if (got.threshold_out !== want.threshold_out)
        begin
            $error("threshold_out mismatch: expected %0d, actual %0d",
                   want.threshold_out, got.threshold_out);
            mismatch_count++;
        end
        if (got.time_stamp_out !== want.time_stamp_out)
        begin
            $error("time_stamp_out mismatch: expected %h, actual %h",
                   want.time_stamp_out, got.time_stamp_out);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            span           = PERIOD_RESET;
            thr            = THRESHOLD_RESET;
            mismatch_count = 0;
            clear_window();
            expected_rsi.delete();
        end
        else
        begin
            if (cfg_we)
                apply_write(cfg_index, cfg_data);
            if (push && !full)
                predict_rsi(in_item);
            if (pop && !empty)
                check_rsi(out_item);
        end
        rsi_outstanding = expected_rsi.size();
    end

endmodule

/* bench/simple_average_rsi_core_tb.sv */
// testbench top for simple_average_rsi_core: clock, reset, price stimulus and verdict
module simple_average_rsi_core_tb;
    import sarsi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_ITEMS   = 520;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_PERIOD_LEN;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  push      = 1'b0;
    logic                  full;
    in_item_t              in_item   = '0;
    logic                  empty;
    logic                  pop       = 1'b0;
    out_item_t             out_item;

    int mismatch_count;
    int rsi_outstanding;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_req    = 1'b0;

    simple_average_rsi_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item)
    );

    sarsi_result_check i_result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .push            (push),
        .full            (full),
        .in_item         (in_item),
        .empty           (empty),
        .pop             (pop),
        .out_item        (out_item),
        .mismatch_count  (mismatch_count),
        .rsi_outstanding (rsi_outstanding)
    );

    always #5 clk = ~clk;

    function automatic logic [TS_W-1:0] rand_stamp();
        return {$urandom(), $urandom()};
    endfunction

    // 0 random, 1 small walk, 2 rising, 3 falling, 4 flat, 5 rail to rail
    function automatic logic [PRICE_IN_W-1:0] next_price(int mode, logic [PRICE_IN_W-1:0] last);
        if ($urandom_range(24) == 0)
            return $urandom();
        case (mode)
            1: return $urandom_range(1) ? last + $urandom_range(2000) : last - $urandom_range(2000);
            2: return last + $urandom_range(50);
            3: return last - $urandom_range(50);
            4: return last;
            5: return $urandom_range(1) ? '1 : '0;
            default: return $urandom();
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_price(logic [PRICE_IN_W-1:0] price, logic [TS_W-1:0] stamp);
        in_item_t item;
        item.price      = price;
        item.time_stamp = stamp;
        push    <= 1'b1;
        in_item <= item;
        do
            @(posedge clk);
        while (full);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    endtask

    // pause the sender until every pending result has been transferred
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        wait (rsi_outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_config(bit force_short);
        int                    pick;
        logic [CFG_DATA_W-1:0] data;
        pick = $urandom_range(7);
        case (pick)
            0: data = {16'($urandom()), 7'd1};
            1: data = {16'($urandom()), 7'd64};
            2: data = {16'($urandom()), 7'd0};
            3: data = {16'($urandom()), 7'd127};
            4: data = {16'($urandom()), 7'($urandom_range(17, 64))};
            default: data = {16'($urandom()), 7'($urandom_range(2, 16))};
        endcase
        if (force_short)
            data = {16'($urandom()), 7'd4};
        if (force_short || $urandom_range(3) != 0)
            write_reg(CFG_PERIOD_LEN, data);
        case ($urandom_range(5))
            0: data = '0;
            1: data = 23'd6553600;
            2: data = '1;
            default: data = 23'($urandom());
        endcase
        write_reg(CFG_THRESHOLD_LEVEL, data);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                pop <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
            end
            else
                pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial
    begin : stimulus
        logic [PRICE_IN_W-1:0] reset_prices [15];
        logic [PRICE_IN_W-1:0] unit_prices [7];
        int                    tx_pcts [3];
        int                    rx_pcts [3];
        logic [PRICE_IN_W-1:0] last;
        int                    sent;
        int                    seg_len;
        int                    mode;
        bit                    first_seg;

        reset_prices = '{32'h0, 32'hFFFFFFFF, 32'h0, 32'h80000000, 32'h7FFFFFFF,
                         32'hFFFFFFFF, 32'hFFFFFFFF, 32'h1, 32'h0, 32'h12345678,
                         32'h12345678, 32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFE, 32'h0};
        // flat, no falls, no rises, flat, no falls, no rises
        unit_prices  = '{32'h0, 32'h0, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h7, 32'h3};
        tx_pcts      = '{17, 53, 0};
        rx_pcts      = '{53, 17, 0};
        last         = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset period and threshold, one result from a mixed window
        for (int i = 0; i < 15; i++)
            send_price(reset_prices[i], (i == 3) ? '0 : (i == 14) ? '1 : rand_stamp());
        settle();

        // period zero acts as one, threshold at its widest value
        write_reg(CFG_PERIOD_LEN, '0);
        write_reg(CFG_THRESHOLD_LEVEL, '1);
        for (int i = 0; i < 7; i++)
            send_price(unit_prices[i], (i == 2) ? '0 : rand_stamp());

        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct = tx_pcts[ph];
            rx_idle_pct = rx_pcts[ph];
            sent        = 0;
            first_seg   = 1'b1;
            while (sent < PHASE_ITEMS)
            begin
                settle();
                random_config(first_seg && ph == 2);
                seg_len = $urandom_range(40, 120);
                mode    = $urandom_range(9);
                if (mode > 5)
                    mode = 1;
                last = $urandom();
                for (int i = 0; i < seg_len; i++)
                begin
                    last = next_price(mode, last);
                    if (first_seg && ph == 2 && i == 10)
                        hold_req = 1'b1;
                    send_price(last, rand_stamp());
                end
                sent += seg_len;
                first_seg = 1'b0;
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
